>>> hdl/sliding_window_segmenter_macros.svh
`ifndef SLIDING_WINDOW_SEGMENTER_MACROS_SVH
`define SLIDING_WINDOW_SEGMENTER_MACROS_SVH

// clocked check, switched off while reset is high
`define SWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked check that also holds across reset
`define SWS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> hdl/swseg_pkg.sv
package swseg_pkg;

  localparam int WINDOW_DEPTH_DEF = 256;
  localparam int SAMPLE_W         = 16;
  localparam int INDEX_W          = 32;
  localparam int THR_W            = 21;
  localparam logic [THR_W-1:0] THR_RESET = 21'd16;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_SCAN,
    ST_COMMIT
  } seg_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic setup;
    logic start;
    logic commit;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic room;
  } dp_status_t;

  // one breakpoint transaction
  typedef struct packed {
    logic [INDEX_W-1:0] brk_index;
    logic               forced;
    logic               last;
  } result_t;

endpackage

>>> hdl/swseg_ram.sv
module swseg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/swseg_outq.sv
module swseg_outq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 push_n,
  input  swseg_pkg::result_t         push_a,
  input  swseg_pkg::result_t         push_b,
  output logic [1:0]                 count,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [swseg_pkg::INDEX_W-1:0] m_tdata,  // break_index
  output logic                       m_tuser,     // forced
  output logic                       m_tlast      // last_of_run
);
  import swseg_pkg::*;

  result_t slot [2];
  logic    head;
  logic    wp;
  logic    pop;

  assign pop = m_tvalid & m_tready;
  assign wp  = head ^ count[0];

  // two-entry queue, up to two pushes per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) begin
        head <= ~head;
      end
      count <= count + push_n - {1'b0, pop};
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slot[wp] <= push_a;
    end
    if (push_n == 2'd2) begin
      slot[~wp] <= push_b;
    end
  end

  // head entry drives the output
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = slot[head].brk_index;
  assign m_tuser  = slot[head].forced;
  assign m_tlast  = slot[head].last;

endmodule

>>> hdl/swseg_dp.sv
module swseg_dp #(
  parameter int WINDOW_DEPTH = swseg_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [swseg_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                          s_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swseg_pkg::THR_W-1:0]   cfg_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swseg_pkg::INDEX_W-1:0] m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  swseg_pkg::ctrl_cmd_t          cmd,
  output swseg_pkg::dp_status_t         status
);
  import swseg_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int PW = AW + 18;
  localparam int EW = PW + 5;
  localparam int LW = THR_W + AW;
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);

  // control and sample state
  logic [THR_W-1:0]   thr;
  logic [FW-1:0]      fill;
  logic [INDEX_W-1:0] count;
  logic [INDEX_W-1:0] idx;
  logic [15:0]        sample;
  logic               last_r;
  logic               fresh;
  logic               forced;
  logic [AW-1:0]      m;
  logic [15:0]        y0;
  logic [15:0]        prev;

  // scan pipeline
  logic [LW-1:0]        limit;
  logic [16:0]          dy;
  logic                 issuing;
  logic [AW-1:0]        k;
  logic signed [PW-1:0] acc;
  logic                 s1_valid;
  logic signed [PW-1:0] s1_acc;
  logic signed [PW-1:0] prod;
  logic                 s2_valid;
  logic signed [PW-1:0] s2_acc;
  logic                 hit;

  // combinational
  logic [THR_W-1:0]     thr_eff;
  logic [15:0]          rd_data;
  logic signed [16:0]   diff;
  logic signed [PW-1:0] prod_c;
  logic signed [PW:0]   sum_c;
  logic signed [EW-1:0] e_c;
  logic [EW-1:0]        mag;
  logic [1:0]           n;
  logic [1:0]           q_count;
  logic [1:0]           push_n;
  logic [INDEX_W-1:0]   idx_prev;
  result_t              res_a;
  result_t              res_b;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  assign thr_eff = (thr == '0) ? THR_W'(1) : thr;

  // window buffer, entry zero lives in y0
  assign ram_we    = cmd.commit & ~fresh;
  assign ram_waddr = hit ? AW'(1) : m;

  swseg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample),
    .raddr (k),
    .rdata (rd_data)
  );

  // item capture and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        fill  <= '0;
        count <= '0;
      end else begin
        count <= idx + 32'd1;
        if (fresh) begin
          fill <= FW'(1);
        end else if (hit) begin
          fill <= FW'(2);
        end else begin
          fill <= FW'(m) + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample <= s_tdata;
      last_r <= s_tlast;
      idx    <= count;
      fresh  <= (fill == '0);
      forced <= (fill == FILL_FULL);
      if (fill == '0) begin
        m <= '0;
      end else if (fill == FILL_FULL) begin
        m  <= AW'(1);
        y0 <= prev;
      end else begin
        m <= fill[AW-1:0];
      end
    end
    if (cmd.setup) begin
      limit <= thr_eff * m;
      dy    <= {sample[15], sample} - {y0[15], y0};
    end
    if (cmd.commit) begin
      prev <= sample;
      if (fresh) begin
        y0 <= sample;
      end else if (hit) begin
        y0 <= prev;
      end
    end
  end

  // deviation arithmetic
  assign diff   = {y0[15], y0} - {rd_data[15], rd_data};
  assign prod_c = diff * $signed({1'b0, m});
  assign sum_c  = {prod[PW-1], prod} + {s2_acc[PW-1], s2_acc};
  assign e_c    = {sum_c, 4'b0000};
  assign mag    = e_c[EW-1] ? -e_c : e_c;

  // scan over interior positions: address, multiply, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      if (cmd.setup) begin
        hit <= 1'b0;
      end
      if (cmd.start) begin
        issuing <= (m > AW'(1));
        k       <= AW'(1);
        acc     <= {{(PW-17){dy[16]}}, dy};
      end else if (issuing) begin
        k   <= k + AW'(1);
        acc <= acc + {{(PW-17){dy[16]}}, dy};
        if (k == m - AW'(1)) begin
          issuing <= 1'b0;
        end
      end
      s1_valid <= issuing;
      s1_acc   <= acc;
      s2_valid <= s1_valid;
      s2_acc   <= s1_acc;
      prod     <= prod_c;
      if (s2_valid && (mag >= {2'b00, limit})) begin
        hit <= 1'b1;
      end
    end
  end

  assign status.scan_done = ~issuing & ~s1_valid & ~s2_valid;

  // results of the current item
  assign idx_prev = idx - 32'd1;
  assign n        = {1'b0, forced} + {1'b0, hit} + {1'b0, last_r};

  always_comb begin
    res_a.brk_index = (forced | hit) ? idx_prev : idx;
    res_a.forced    = forced;
    res_a.last      = (n == 2'd1);
    res_b.brk_index = idx;
    res_b.forced    = 1'b0;
    res_b.last      = 1'b1;
  end

  assign status.room = ({1'b0, q_count} + {1'b0, n}) <= 3'd2;
  assign push_n      = cmd.commit ? n : 2'd0;

  swseg_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push_a   (res_a),
    .push_b   (res_b),
    .count    (q_count),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hdl/swseg_ctrl.sv
module swseg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  swseg_pkg::dp_status_t status,
  output swseg_pkg::ctrl_cmd_t  cmd
);
  import swseg_pkg::*;

  seg_state_t state;
  seg_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_START;
      ST_START: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_SETUP:  cmd.setup  = 1'b1;
      ST_START:  cmd.start  = 1'b1;
      ST_SCAN:   cmd        = '0;
      ST_COMMIT: cmd.commit = status.room;
      default:   cmd        = '0;
    endcase
  end

endmodule

>>> hdl/sliding_window_segmenter.sv
// sequencing: an accepted sample goes through setup, start, scan and commit; the
//   scan reads one buffered sample per cycle over interior positions 1 to m - 1,
//   m being the sample's window position (at most WINDOW_DEPTH - 1), and reads
//   nothing when m is 0 or 1; the next sample is taken only after the commit, and
//   a full result queue stalls the commit
// reset: rst clears control state, threshold returns to 16, window is empty,
//   sample index restarts at 0; ram contents are not cleared
module sliding_window_segmenter #(
  parameter int WINDOW_DEPTH = swseg_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swseg_pkg::SAMPLE_W-1:0] s_tdata,  // sample
  input  logic                          s_tlast,   // is_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swseg_pkg::INDEX_W-1:0] m_tdata,   // break_index
  output logic                          m_tuser,   // forced
  output logic                          m_tlast,   // last_of_run
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swseg_pkg::THR_W-1:0]   cfg_data   // error_threshold
);
  import swseg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  swseg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swseg_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> hdl/swseg_checker.sv
`include "sliding_window_segmenter_macros.svh"

module swseg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [swseg_pkg::INDEX_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);

  logic                            in_take;
  logic                            out_stall;
  logic [swseg_pkg::INDEX_W+1:0]   out_payload;

  assign in_take     = s_tvalid && s_tready;
  assign out_stall   = m_tvalid && !m_tready;
  assign out_payload = {m_tdata, m_tuser, m_tlast};

  // stalled result holds its payload
  `SWS_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(out_payload), "stalled result changed")

  // an accepted sample keeps the input closed through the setup and start states
  `SWS_ASSERT(a_in_busy, in_take |=> !s_tready ##1 !s_tready, "input reopened too early")

  // after reset the block is idle with an empty result queue
  `SWS_ASSERT_RST(a_reset_idle, rst |=> s_tready && !m_tvalid, "not idle after reset")

endmodule

bind sliding_window_segmenter swseg_checker u_checker (.*);

>>> tb/sv/sliding_window_segmenter_tb.sv
`timescale 1ns / 100ps

module sliding_window_segmenter_tb;
  import swseg_pkg::*;

  localparam int WIN_DEPTH    = WINDOW_DEPTH_DEF;
  localparam int DRAIN_CYCLES = WIN_DEPTH + 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                fin;
  } sample_item_t;

  typedef enum int {
    SHAPE_LINE,
    SHAPE_WALK,
    SHAPE_NOISE,
    SHAPE_FLAT
  } series_shape_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;  // sample
  logic                s_tlast = 1'b0;  // is_last
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [INDEX_W-1:0]  m_tdata;  // break_index
  logic                m_tuser;  // forced
  logic                m_tlast;  // last_of_run
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [THR_W-1:0]    cfg_data = '0;  // error_threshold

  // stimulus and expectation stores
  sample_item_t sample_queue[$];
  result_t      expected_breaks[$];
  result_t      want_brk;
  int           samples_queued = 0;
  int           samples_taken = 0;
  int           error_cnt = 0;
  int           cycle_cnt = 0;

  // segmenter shadow state
  logic signed [SAMPLE_W-1:0] seg_win[WIN_DEPTH];
  int unsigned                seg_fill = 0;
  logic [INDEX_W-1:0]         seg_next_idx = '0;
  logic [THR_W-1:0]           thr_model = THR_RESET;

  // idling state of both sides
  int feed_gap = 0;
  bit feed_burst = 1'b0;
  int drain_wait = 0;
  bit drain_burst = 1'b0;

  sliding_window_segmenter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // true when some interior sample is too far from the anchor-to-newest line
  function automatic bit line_fit_broken();
    longint mm, y0, ym, lim, e;
    mm = longint'(seg_fill - 1);
    y0 = seg_win[0];
    ym = seg_win[seg_fill - 1];
    lim = longint'((thr_model == '0) ? 21'd1 : thr_model) * mm;
    for (longint k = 1; k < mm; k++) begin
      e = ((y0 - longint'(seg_win[k])) * mm + (ym - y0) * k) * 16;
      if (e < 0) e = -e;
      if (e >= lim) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void note_break(logic [INDEX_W-1:0] idx, logic forced);
    result_t b;
    b.brk_index = idx;
    b.forced = forced;
    b.last = 1'b0;
    expected_breaks.insert(expected_breaks.size(), b);
  endfunction

  // advance the shadow segmenter by one sample and queue its breakpoints
  function automatic void predict_breaks(logic [SAMPLE_W-1:0] raw, logic fin);
    logic [INDEX_W-1:0] idx;
    int first;
    idx = seg_next_idx;
    first = expected_breaks.size();
    if (seg_fill == 0) begin
      seg_win[0] = raw;
      seg_fill = 1;
    end else begin
      if (seg_fill == WIN_DEPTH) begin
        note_break(idx - 1, 1'b1);
        seg_win[0] = seg_win[seg_fill - 1];
        seg_fill = 1;
      end
      seg_win[seg_fill] = raw;
      seg_fill++;
      if (line_fit_broken()) begin
        note_break(idx - 1, 1'b0);
        seg_win[0] = seg_win[seg_fill - 2];
        seg_win[1] = seg_win[seg_fill - 1];
        seg_fill = 2;
      end
    end
    if (fin) begin
      note_break(idx, 1'b0);
      seg_fill = 0;
      seg_next_idx = '0;
    end else begin
      seg_next_idx = idx + 1;
    end
    if (expected_breaks.size() > first) expected_breaks[$].last = 1'b1;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_breaks(s_tdata, s_tlast);
        samples_taken++;
        if ($urandom_range(0, 31) == 0) feed_burst = !feed_burst;
        feed_gap = feed_burst ? 0 : $urandom_range(0, 15);
      end
      if (!s_tvalid || s_tready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          sample_item_t nxt;
          nxt = sample_queue.pop_front();
          s_tdata <= nxt.value;
          s_tlast <= nxt.fin;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // breakpoint monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      drain_wait = $urandom_range(0, 15);
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_breaks.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got index %0d forced %0b last %0b",
                   $time, m_tdata, m_tuser, m_tlast);
          error_cnt++;
        end else begin
          want_brk = expected_breaks.pop_front();
          if (m_tdata !== want_brk.brk_index) begin
            $display("%0t: break_index expected %0d, got %0d", $time, want_brk.brk_index, m_tdata);
            error_cnt++;
          end
          if (m_tuser !== want_brk.forced) begin
            $display("%0t: forced expected %0b, got %0b", $time, want_brk.forced, m_tuser);
            error_cnt++;
          end
          if (m_tlast !== want_brk.last) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time, want_brk.last, m_tlast);
            error_cnt++;
          end
        end
        if ($urandom_range(0, 15) == 0) drain_burst = !drain_burst;
        drain_wait = drain_burst ? 0 : $urandom_range(0, 15);
      end
      if (drain_wait > 0) begin
        drain_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [SAMPLE_W-1:0] value, input logic fin);
    sample_item_t it;
    it.value = value;
    it.fin = fin;
    sample_queue.insert(sample_queue.size(), it);
    samples_queued++;
  endtask

  // one series of len samples, the last one flagged
  task automatic queue_series(input int len, input series_shape_t shape, input int amp);
    int base, slope, v;
    base = int'($urandom_range(0, 65535)) - 32768;
    slope = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4000)) - 2000
                                        : int'($urandom_range(0, 40)) - 20;
    v = base;
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_LINE: begin
          v = base + slope * i + int'($urandom_range(0, 2 * amp)) - amp;
        end
        SHAPE_WALK: begin
          v = v + int'($urandom_range(0, 2 * amp)) - amp;
        end
        SHAPE_NOISE: begin
          v = int'($urandom_range(0, 65535));
        end
        default: begin
          v = base;
        end
      endcase
      queue_item(v[SAMPLE_W-1:0], i == len - 1);
    end
  endtask

  // whole series of mixed shapes, count samples in all
  task automatic queue_random_series(input int count);
    int n, len, amp;
    series_shape_t shape;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      if (len > count - n) len = count - n;
      shape = series_shape_t'($urandom_range(0, 3));
      amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 6);
      queue_series(len, shape, amp);
      n += len;
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    @(posedge clk);
    cfg_data <= thr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_model = thr;
  endtask

  // wait until every sample is taken and every breakpoint seen, then let the scan settle
  task automatic finish_phase();
    while (samples_taken != samples_queued || expected_breaks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: one-sample series
    queue_item(16'h0000, 1'b1);
    // full-scale swings, threshold break together with end of series
    queue_item(16'h7FFF, 1'b0);
    queue_item(16'h8000, 1'b0);
    queue_item(16'h7FFF, 1'b0);
    queue_item(16'h8000, 1'b1);
    // near-straight line, then a sharp turn
    queue_item(16'd0, 1'b0);
    queue_item(16'd2, 1'b0);
    queue_item(16'd4, 1'b0);
    queue_item(16'd6, 1'b0);
    queue_item(16'd8, 1'b0);
    queue_item(16'd9, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd100, 1'b1);
    // two-sample series
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd1, 1'b1);
    queue_random_series(30);
    finish_phase();

    // smallest threshold
    write_threshold(21'd1);
    queue_random_series(15);
    finish_phase();

    // zero threshold acts as the smallest one
    write_threshold('0);
    queue_random_series(10);
    finish_phase();

    // largest threshold never breaks, so the window fills and forces a break
    write_threshold(THR_MAX);
    queue_series(WIN_DEPTH + 2, SHAPE_NOISE, 0);
    finish_phase();

    // forced break landing on the final sample
    write_threshold(THR_W'($urandom_range(16, 4000)));
    queue_series(WIN_DEPTH + 1, SHAPE_FLAT, 0);
    queue_random_series(10);
    finish_phase();

    // random small threshold
    write_threshold(THR_W'($urandom_range(2, 300)));
    queue_random_series(20);
    finish_phase();

    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/swseg_pkg.sv
hdl/swseg_ram.sv
hdl/swseg_outq.sv
hdl/swseg_dp.sv
hdl/swseg_ctrl.sv
hdl/sliding_window_segmenter.sv
hdl/swseg_checker.sv
tb/sv/sliding_window_segmenter_tb.sv
